>>> design/lzss_stream_decoder_assert.svh
// assertion macros for the decoder checker
`ifndef LZSS_STREAM_DECODER_ASSERT_SVH
`define LZSS_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LZSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lzsd assertion failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LZSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lzsd assertion failed");

`endif

>>> design/lzsd_pkg.sv
package lzsd_pkg;

    // one compressed byte request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic       run_last;
        logic       stream_end;
    } t_out_item;

    // result kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // stream format
    localparam logic [2:0] HDR_LAST_IDX  = 3'd7;
    localparam logic [3:0] TOK_FLAG_NEXT = 4'd8;
    localparam int unsigned POS_BIAS = 18;
    localparam int unsigned LEN_BIAS = 3;

endpackage

>>> design/lzsd_window.sv
module lzsd_window
    import lzsd_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // history store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lzsd_out_buf.sv
module lzsd_out_buf
    import lzsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    // slot can be reloaded when empty or being drained this cycle
    assign o_free = !r_valid || i_out_ready;

    // output holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

>>> design/lzss_stream_decoder.sv
// lzss stream decoder
// input channel: one compressed byte per request (i_in_valid / o_in_ready),
// with in_last on the final byte of a stream; header bytes included
// output channel: one decoded byte per request (o_out_valid / i_out_ready),
// run_last marks the final result of an input byte, stream_end the byte
// that reaches the stated size; a stream cut inside its header gives one
// result of kind error
// steps: each input byte is captured in the idle step, then processed;
// a literal, or a header byte cut by in_last, waits there for a free
// output register; a second match byte then copies length bytes (length
// 3 to 18), each a read step then an emit step on the single window port
// pair; the stated size may cut a copy short
// the output register lets the next byte be captured while a result waits;
// a stalled receiver holds the sequencer in its process or emit step
// reset and each in_last return the parser to the header state; the window
// is not swept, a fill count makes unwritten entries read as zero
module lzss_stream_decoder
    import lzsd_pkg::*;
#(
    parameter int WINDOW_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_READ,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_MATCH2,
        PH_DONE
    } t_phase;

    localparam int WB = WINDOW_BITS;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [2:0]        r_hdr_cnt, n_hdr_cnt;
    logic [31:0]       r_total, n_total;
    logic [31:0]       r_prod, n_prod;
    logic              r_full, n_full;
    logic [7:0]        r_flags, n_flags;
    logic [3:0]        r_tok_idx, n_tok_idx;
    logic [7:0]        r_low, n_low;
    logic [4:0]        r_len, n_len;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic [WB-1:0]     r_src, n_src;
    logic              r_rd_ok, n_rd_ok;

    logic              w_ob_free;
    logic              w_push;
    t_out_item         w_item;
    logic              w_we;
    logic [7:0]        w_wdata;
    logic              w_re;
    logic [7:0]        w_rdata;
    logic [7:0]        w_rd_byte;
    logic [31:0]       w_prod_inc;
    logic              w_end;
    logic              w_finish;
    logic              w_run_last;
    logic [12:0]       w_pos_sum;

    // window store
    lzsd_window #(
        .ADDR_W (WB)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_prod[WB-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_src),
        .o_rdata (w_rdata)
    );

    // result register
    lzsd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_item),
        .o_free      (w_ob_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    assign o_in_ready = (r_state == S_IDLE);

    // shared count and size compare, used by every emitted data byte
    assign w_prod_inc = r_prod + 32'd1;
    assign w_end      = (w_prod_inc == r_total);
    assign w_rd_byte  = r_rd_ok ? w_rdata : 8'd0;
    assign w_run_last = w_end || (r_len == 5'd1);
    assign w_pos_sum  = {1'b0, r_byte[7:4], r_low} + 13'(POS_BIAS);

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_total   = r_total;
        n_prod    = r_prod;
        n_full    = r_full;
        n_flags   = r_flags;
        n_tok_idx = r_tok_idx;
        n_low     = r_low;
        n_len     = r_len;
        n_byte    = r_byte;
        n_last    = r_last;
        n_src     = r_src;
        n_rd_ok   = r_rd_ok;
        w_push    = 1'b0;
        w_item    = '0;
        w_we      = 1'b0;
        w_wdata   = r_byte;
        w_re      = 1'b0;
        w_finish  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_in_item.in_byte;
                    n_last  = i_in_item.in_last;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_hdr_cnt == HDR_LAST_IDX) begin
                            n_phase  = (r_total == 32'd0) ? PH_DONE : PH_BODY;
                            w_finish = 1'b1;
                        end else if (!r_last || w_ob_free) begin
                            // size bytes come first, reserved bytes are skipped
                            if (!r_hdr_cnt[2]) begin
                                n_total[{r_hdr_cnt[1:0], 3'b000} +: 8] = r_byte;
                            end
                            n_hdr_cnt = r_hdr_cnt + 3'd1;
                            if (r_last) begin
                                w_push          = 1'b1;
                                w_item.out_byte = 8'd0;
                                w_item.out_kind = KIND_ERROR;
                                w_item.run_last = 1'b1;
                            end
                            w_finish = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        if (r_tok_idx[3]) begin
                            // new flag byte
                            n_flags   = r_byte;
                            n_tok_idx = 4'd0;
                            w_finish  = 1'b1;
                        end else if (r_flags[r_tok_idx[2:0]]) begin
                            // literal
                            if (w_ob_free) begin
                                n_tok_idx = r_tok_idx + 4'd1;
                                w_we      = 1'b1;
                                w_push    = 1'b1;
                                w_item.out_byte   = r_byte;
                                w_item.out_kind   = KIND_DATA;
                                w_item.run_last   = 1'b1;
                                w_item.stream_end = w_end;
                                n_prod = w_prod_inc;
                                if (&r_prod[WB-1:0]) begin
                                    n_full = 1'b1;
                                end
                                if (w_end) begin
                                    n_phase = PH_DONE;
                                end
                                w_finish = 1'b1;
                            end
                        end else begin
                            // first match byte
                            n_low    = r_byte;
                            n_phase  = PH_MATCH2;
                            w_finish = 1'b1;
                        end
                    end
                    PH_MATCH2: begin
                        n_len     = 5'(r_byte[3:0]) + 5'(LEN_BIAS);
                        n_src     = w_pos_sum[WB-1:0];
                        n_tok_idx = r_tok_idx + 4'd1;
                        n_phase   = PH_BODY;
                        n_state   = S_READ;
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                // entries not yet written this stream read as zero
                w_re    = 1'b1;
                n_rd_ok = r_full || (r_src < r_prod[WB-1:0]);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_ob_free) begin
                    w_we              = 1'b1;
                    w_wdata           = w_rd_byte;
                    w_push            = 1'b1;
                    w_item.out_byte   = w_rd_byte;
                    w_item.out_kind   = KIND_DATA;
                    w_item.run_last   = w_run_last;
                    w_item.stream_end = w_end;
                    n_prod = w_prod_inc;
                    if (&r_prod[WB-1:0]) begin
                        n_full = 1'b1;
                    end
                    n_src = r_src + WB'(1);
                    n_len = r_len - 5'd1;
                    if (w_end) begin
                        n_phase = PH_DONE;
                    end
                    if (w_run_last) begin
                        w_finish = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of byte, and stream restart after the final byte
        if (w_finish) begin
            n_state = S_IDLE;
            if (r_last) begin
                n_phase   = PH_HEADER;
                n_hdr_cnt = 3'd0;
                n_total   = 32'd0;
                n_prod    = 32'd0;
                n_full    = 1'b0;
                n_flags   = 8'd0;
                n_tok_idx = TOK_FLAG_NEXT;
                n_low     = 8'd0;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_total   <= 32'd0;
            r_prod    <= 32'd0;
            r_full    <= 1'b0;
            r_flags   <= 8'd0;
            r_tok_idx <= TOK_FLAG_NEXT;
            r_low     <= 8'd0;
            r_len     <= 5'd0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_total   <= n_total;
            r_prod    <= n_prod;
            r_full    <= n_full;
            r_flags   <= n_flags;
            r_tok_idx <= n_tok_idx;
            r_low     <= n_low;
            r_len     <= n_len;
            r_last    <= n_last;
        end
        r_byte  <= n_byte;
        r_src   <= n_src;
        r_rd_ok <= n_rd_ok;
    end

endmodule

>>> design/lzsd_checker.sv
`include "lzss_stream_decoder_assert.svh"

module lzsd_checker
    import lzsd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic w_out_stall;
    logic w_is_err;
    logic w_err_ok;
    logic w_is_end;
    logic w_end_ok;
    logic w_in_take;

    // views of the two channels
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_is_err    = o_out_valid && (o_out_item.out_kind == KIND_ERROR);
    assign w_err_ok    = (o_out_item.out_byte == 8'd0) && o_out_item.run_last
                         && !o_out_item.stream_end;
    assign w_is_end    = o_out_valid && o_out_item.stream_end;
    assign w_end_ok    = (o_out_item.out_kind == KIND_DATA) && o_out_item.run_last;
    assign w_in_take   = i_in_valid && o_in_ready;

    // a waiting result holds until taken
    `LZSD_ASSERT_NXT(a_out_hold, w_out_stall, o_out_valid && $stable(o_out_item))

    // an error result is a lone zero byte that ends its request
    `LZSD_ASSERT_IMP(a_err_form, w_is_err, w_err_ok)

    // the byte reaching the size is data and closes its request
    `LZSD_ASSERT_IMP(a_end_form, w_is_end, w_end_ok)

    // the block is not ready again in the cycle after it captures a byte
    `LZSD_ASSERT_NXT(a_busy_after_req, w_in_take, !o_in_ready)

endmodule

bind lzss_stream_decoder lzsd_checker u_lzsd_checker (.*);

>>> verif/lzsd_checker.sv
`timescale 1ns / 1ps

module lzsd_tb_checker
    import lzsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    output int unsigned o_error_count,
    output int unsigned o_pending
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_MATCH2,
        PH_DONE
    } t_phase;

    localparam int unsigned WIN_DEPTH = 4096;
    localparam int unsigned MAX_RUN   = 18;

    // decoder state as the block should hold it
    t_phase      phase;
    logic [2:0]  hdr_count;
    logic [31:0] size_target;
    logic [31:0] size_done;
    logic [7:0]  flag_bits;
    logic [3:0]  token_slot;
    logic [7:0]  copy_low;
    logic [7:0]  history [WIN_DEPTH];

    // results of the request being decoded, then the queue of decoded bytes
    t_out_item   run_buf [MAX_RUN];
    int unsigned run_len;
    t_out_item   decoded_q [$];
    int unsigned mismatches = 0;

    // back to the header state with an empty window
    task clear_stream();
        phase       = PH_HEADER;
        hdr_count   = '0;
        size_target = '0;
        size_done   = '0;
        flag_bits   = '0;
        token_slot  = TOK_FLAG_NEXT;
        copy_low    = '0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            history[i] = '0;
        end
    endtask

    // one decoded byte into the window and the run
    task emit_decoded(input logic [7:0] value);
        logic reached;
        history[size_done[11:0]] = value;
        size_done = size_done + 1;
        reached = (size_done == size_target);
        if (reached) begin
            phase = PH_DONE;
        end
        run_buf[run_len] = '{out_byte: value, out_kind: KIND_DATA,
                             run_last: 1'b0, stream_end: reached};
        run_len++;
    endtask

    // work out the results one compressed byte causes
    task decode_byte(input t_in_item item);
        logic [11:0] src;
        logic [4:0]  copy_len;
        run_len = 0;
        case (phase)
            PH_HEADER: begin
                if (hdr_count < 3'd4) begin
                    size_target = size_target
                                | (32'(item.in_byte) << {hdr_count[1:0], 3'b000});
                end
                if (hdr_count == HDR_LAST_IDX) begin
                    phase = (size_target == 0) ? PH_DONE : PH_BODY;
                end else begin
                    hdr_count = hdr_count + 3'd1;
                    // stream cut inside its header
                    if (item.in_last) begin
                        run_buf[0] = '{out_byte: 8'h00, out_kind: KIND_ERROR,
                                       run_last: 1'b0, stream_end: 1'b0};
                        run_len = 1;
                    end
                end
            end
            PH_BODY: begin
                if (token_slot >= TOK_FLAG_NEXT) begin
                    flag_bits  = item.in_byte;
                    token_slot = '0;
                end else if (flag_bits[token_slot[2:0]]) begin
                    token_slot = token_slot + 4'd1;
                    emit_decoded(item.in_byte);
                end else begin
                    copy_low = item.in_byte;
                    phase    = PH_MATCH2;
                end
            end
            PH_MATCH2: begin
                copy_len   = 5'(item.in_byte[3:0]) + 5'(LEN_BIAS);
                src        = {item.in_byte[7:4], copy_low} + 12'(POS_BIAS);
                token_slot = token_slot + 4'd1;
                phase      = PH_BODY;
                // byte by byte, so a copy may overlap its own output
                for (int i = 0; i < copy_len && phase != PH_DONE; i++) begin
                    emit_decoded(history[src]);
                    src = src + 12'd1;
                end
            end
            default: begin
            end
        endcase
        if (run_len > 0) begin
            run_buf[run_len - 1].run_last = 1'b1;
        end
        for (int i = 0; i < run_len; i++) begin
            decoded_q.push_back(run_buf[i]);
        end
        if (item.in_last) begin
            clear_stream();
        end
    endtask

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // compare one result request with the oldest decoded byte
    task check_result(input t_out_item got);
        t_out_item want;
        if (decoded_q.size() == 0) begin
            report_mismatch("unexpected result", got.out_byte, 8'h00);
            return;
        end
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", got.out_byte, want.out_byte);
        end
        if (got.out_kind !== want.out_kind) begin
            report_mismatch("out_kind", 8'(got.out_kind), 8'(want.out_kind));
        end
        if (got.run_last !== want.run_last) begin
            report_mismatch("run_last", 8'(got.run_last), 8'(want.run_last));
        end
        if (got.stream_end !== want.stream_end) begin
            report_mismatch("stream_end", 8'(got.stream_end), 8'(want.stream_end));
        end
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_stream();
            decoded_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_item);
            end
        end
        o_pending     <= decoded_q.size();
        o_error_count <= mismatches;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lzsd_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 260;
    localparam int unsigned IDLE_PCT     = 32;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned QUIET_FROM   = 100;
    localparam int unsigned QUIET_TO     = 160;
    localparam int unsigned RUN_LIMIT_NS = 2000000;

    typedef enum int unsigned {
        END_EXACT,
        END_TRAILING,
        END_EARLY,
        END_CUT_MATCH
    } t_stream_end;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        quiet     = 1'b0;
    int unsigned error_count;
    int unsigned pending;
    int unsigned items_sent = 0;
    logic [7:0]  stream_q [$];

    lzss_stream_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    lzsd_tb_checker decode_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    // receiver stalls at random outside the quiet stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // one compressed byte request, with random idle cycles ahead of it
    task send_byte(input logic [7:0] value, input logic last);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: value, in_last: last};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task send_stream();
        for (int i = 0; i < stream_q.size(); i++) begin
            send_byte(stream_q[i], i == stream_q.size() - 1);
        end
    endtask

    // hold the sender until every decoded byte has come out
    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // size little-endian, then four reserved bytes
    task push_header(input logic [31:0] size);
        for (int i = 0; i < 4; i++) begin
            stream_q.push_back(size[8 * i +: 8]);
        end
        for (int i = 0; i < 4; i++) begin
            stream_q.push_back(8'($urandom));
        end
    endtask

    // lzss body that decodes to at least target bytes; with cut_match it
    // goes on to a match and stops after its first byte
    task build_body(input int unsigned target, input bit cut_match);
        int unsigned made;
        int unsigned slot;
        logic [7:0]  flags;
        logic [11:0] src;
        logic [3:0]  len_code;
        made  = 0;
        slot  = 8;
        flags = '0;
        forever begin
            if (!cut_match && made >= target) begin
                break;
            end
            if (slot == 8) begin
                flags = (cut_match && made >= target) ? 8'h00 : 8'($urandom);
                stream_q.push_back(flags);
                slot = 0;
            end
            if (flags[slot]) begin
                stream_q.push_back(8'($urandom));
                made++;
            end else begin
                len_code = 4'($urandom);
                // mostly recent history, sometimes anywhere in the window
                if (made > 0 && $urandom_range(0, 3) != 0) begin
                    src = 12'(made - $urandom_range(1, (made < 64) ? made : 64));
                end else begin
                    src = 12'($urandom);
                end
                src = src - 12'(POS_BIAS);
                stream_q.push_back(src[7:0]);
                if (cut_match && made >= target) begin
                    break;
                end
                stream_q.push_back({src[11:8], len_code});
                made += len_code + LEN_BIAS;
            end
            slot++;
        end
    endtask

    // a well-formed stream with one of the endings
    task build_stream();
        int unsigned size;
        int unsigned cut;
        t_stream_end ending;
        case ($urandom_range(0, 19))
            0:       size = 0;
            1:       size = $urandom_range(40, 120);
            default: size = $urandom_range(1, 30);
        endcase
        ending = t_stream_end'($urandom_range(0, 3));
        if (ending == END_CUT_MATCH) begin
            push_header(size + 200);
            build_body(size, 1'b1);
        end else begin
            push_header(size);
            build_body(size, 1'b0);
        end
        if (ending == END_TRAILING) begin
            repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom));
        end
        if (ending == END_EARLY && stream_q.size() > 9) begin
            cut = $urandom_range(9, stream_q.size() - 1);
            while (stream_q.size() > cut) begin
                void'(stream_q.pop_back());
            end
        end
    endtask

    initial begin
        int unsigned start;
        int unsigned pick;
        bit          paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stream cut inside its header
        stream_q = '{8'hff};
        send_stream();
        // zero size, body byte ignored
        stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_stream();
        // literal, then a long copy from window start cut at size, then ignored byte
        stream_q = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'hff, 8'hee, 8'hff, 8'h00};
        send_stream();
        wait_drained();

        // random streams, mostly well-formed
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            quiet <= (items_sent - start >= QUIET_FROM) && (items_sent - start < QUIET_TO);
            stream_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 7)) stream_q.push_back(8'($urandom));
            end else if (pick < 25) begin
                repeat ($urandom_range(9, 24)) stream_q.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                    stream_q[0] = 8'($urandom_range(1, 30));
                    stream_q[1] = 8'h00;
                    stream_q[2] = 8'h00;
                    stream_q[3] = 8'h00;
                end
            end else begin
                build_stream();
            end
            send_stream();
            if (!paused && items_sent - start >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        quiet <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
